@@ rtl/tint_pkg.sv @@
// ----------------------------------------------------------------------------
// tint_pkg: shared types and constants of the tickless interval timer
// Command and result codes, channel payload structs, the front-to-back queue
// entry and a helper for the counter mask.
// ----------------------------------------------------------------------------
package tint_pkg;

  // Command codes on the input channel
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_SET      = 3'd1;
  localparam logic [2:0] CMD_RD_UNREP = 3'd2;
  localparam logic [2:0] CMD_RD_TIME  = 3'd3;
  localparam logic [2:0] CMD_ENABLE   = 3'd4;
  localparam logic [2:0] CMD_DISABLE  = 3'd5;

  // Result kinds on the output channel
  localparam logic [1:0] KIND_EXPIRY = 2'd0;
  localparam logic [1:0] KIND_UNREP  = 2'd1;
  localparam logic [1:0] KIND_TIME   = 2'd2;

  localparam logic [15:0] MIN_INTERVAL_RST = 16'd50;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;  // power of two, pointers wrap naturally
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] period_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value_us;
  } out_item_t;

  // Classified operation, as handed to the back end
  typedef enum logic [2:0] {
    OP_TICK,
    OP_SET,
    OP_STOP,
    OP_RD_UNREP,
    OP_RD_TIME,
    OP_ENABLE,
    OP_DISABLE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] req_count;  // clamped interval in counts, saturated
    logic [31:0] min_count;  // minimum interval in counts, saturated
    logic        is_max;     // clamped interval equals the maximum
  } q_item_t;

  // Result before the divide by the clock rate
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] dividend;
  } res_t;

  function automatic logic [31:0] cnt_mask(input int bits);
    logic [63:0] full;
    full = (64'd1 << bits) - 64'd1;
    return full[31:0];
  endfunction

endpackage

@@ rtl/tickless_interval_timer_top.sv @@
// Path: a result leaves through the intake stage, queue, back end, two divide
//   stages and the output register after the command transfer that causes it.
// Intake: one command per cycle while the queue has credit; a set-interval
//   holds the back end (fold, reload pick, two residue passes in the divide pipe).
// Reset (rst, synchronous): counter at zero, reload all ones, totals zero,
//   timer running and enabled, minimum interval 50 us, queue and pipes empty.
// ----------------------------------------------------------------------------
// tickless_interval_timer_top: tickless OS interval timer
// Down-counter timer counting tick commands, with expiry reports and reads in
// whole microseconds, and set-interval reload computation.
// ----------------------------------------------------------------------------
module tickless_interval_timer_top import tint_pkg::*; #(
  parameter int CLOCK_MHZ    = 64,
  parameter int COUNTER_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  in_item_t    cmd_item,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output out_item_t   rsp_item,
  // minimum interval register
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  // Front -> queue
  logic              q_push;
  q_item_t           q_wdata;
  logic [QLVL_W-1:0] q_level;

  // Queue -> back
  logic              q_head_valid;
  q_item_t           q_head;
  logic              q_pop;

  // Back -> output pipe (count-domain result)
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  // Front end: registers the transfer, clamps and converts set-interval
  // requests to counts, drops unused codes. Stalls on queue credit only,
  // so a busy back end does not block intake until the queue fills.
  tint_front #(
    .CLOCK_MHZ   (CLOCK_MHZ),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_item (cmd_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_level  (q_level),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  tint_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_wdata),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_item (q_head),
    .level     (q_level)
  );

  // Back end: one operation per cycle unless in set-interval or backpressured.
  // Expiry keeps the unreported count's residue mod CLOCK_MHZ so a wrap needs
  // no divide in the state loop; the quotient is worked out downstream.
  tint_back #(
    .CLOCK_MHZ   (CLOCK_MHZ),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(q_head_valid),
    .head_item (q_head),
    .pop       (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output: divide by CLOCK_MHZ, then the result register. Backpressure
  // freezes this pipe and the back end holds any result-bearing operation.
  tint_out #(
    .CLOCK_MHZ(CLOCK_MHZ)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_item (rsp_item)
  );

endmodule

@@ rtl/tint_div.sv @@
// ----------------------------------------------------------------------------
// tint_div: pipelined divide by the clock rate
// Reciprocal multiply, back-multiply, then one compare-and-subtract fixup.
// Two register stages; quotient and remainder come out combinationally.
// ----------------------------------------------------------------------------
module tint_div #(
  parameter int CLOCK_MHZ = 64
) (
  input  logic        clk,
  input  logic        advance,
  input  logic [31:0] dividend,
  output logic [31:0] quotient,
  output logic [((CLOCK_MHZ > 1) ? $clog2(CLOCK_MHZ) : 1)-1:0] remainder
);

  localparam int MW = $clog2(CLOCK_MHZ + 1);
  localparam int RW = (CLOCK_MHZ > 1) ? $clog2(CLOCK_MHZ) : 1;
  // floor((2^32-1)/M): estimate is low by at most one
  localparam logic [63:0] RECIP64 = 64'hFFFF_FFFF / 64'(CLOCK_MHZ);
  localparam logic [31:0] RECIP   = RECIP64[31:0];
  localparam logic [31:0] DIVISOR = 32'(CLOCK_MHZ);

  logic [63:0]      prod;
  logic [31:0]      u1;
  logic [31:0]      q0;
  logic [31:0]      u2;
  logic [31:0]      m2;
  logic [31+MW:0]   back_prod;
  logic [31:0]      rem_raw;
  logic             fix;
  logic [31:0]      rem_fixed;

  assign back_prod = (32 + MW)'(prod[63:32]) * (32 + MW)'(CLOCK_MHZ);

  always_ff @(posedge clk) begin
    if (advance) begin
      prod <= 64'(dividend) * 64'(RECIP);
      u1   <= dividend;
      q0   <= prod[63:32];
      u2   <= u1;
      m2   <= back_prod[31:0];
    end
  end

  assign rem_raw   = u2 - m2;
  assign fix       = rem_raw >= DIVISOR;
  assign quotient  = fix ? q0 + 32'd1 : q0;
  assign rem_fixed = fix ? rem_raw - DIVISOR : rem_raw;
  assign remainder = rem_fixed[RW-1:0];

endmodule

@@ rtl/tint_front.sv @@
// ----------------------------------------------------------------------------
// tint_front: command intake and classification
// Holds the minimum-interval register, clamps set-interval requests, converts
// them to counts and pushes classified operations into the queue.
// ----------------------------------------------------------------------------
module tint_front import tint_pkg::*; #(
  parameter int CLOCK_MHZ    = 64,
  parameter int COUNTER_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  in_item_t          cmd_item,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic [QLVL_W-1:0] q_level,
  output logic              q_push,
  output q_item_t           q_wdata
);

  localparam int          MW       = $clog2(CLOCK_MHZ + 1);
  localparam logic [31:0] CNT_MASK = cnt_mask(COUNTER_BITS);
  localparam logic [31:0] MAX_US   = CNT_MASK / 32'(CLOCK_MHZ);

  logic [15:0]    min_interval;
  logic           f1_valid;
  logic [2:0]     f1_cmd;
  logic [31:0]    f1_us;
  logic           f1_forever;
  logic           accept;
  logic           above_max;
  logic           below_min;
  logic [31:0]    us_clamped;
  logic [31+MW:0] set_prod;
  logic [15+MW:0] min_prod;
  logic           known;
  op_t            op;

  // Room for the item already in the intake stage is reserved
  assign cmd_stall = rst || ((q_level + QLVL_W'(f1_valid)) >= QLVL_W'(QUEUE_DEPTH));
  assign accept    = cmd_valid && !cmd_stall;

  assign above_max  = cmd_item.period_us > MAX_US;
  assign below_min  = cmd_item.period_us < 32'(min_interval);
  assign us_clamped = above_max ? MAX_US :
                      below_min ? 32'(min_interval) : cmd_item.period_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= MIN_INTERVAL_RST;
      f1_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_interval <= cfg_wdata;
      end
      f1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_cmd     <= cmd_item.command;
      f1_us      <= us_clamped;
      f1_forever <= &cmd_item.period_us;
    end
  end

  always_comb begin
    known = 1'b1;
    op    = OP_TICK;
    unique case (f1_cmd)
      CMD_TICK:     op = OP_TICK;
      CMD_SET:      op = f1_forever ? OP_STOP : OP_SET;
      CMD_RD_UNREP: op = OP_RD_UNREP;
      CMD_RD_TIME:  op = OP_RD_TIME;
      CMD_ENABLE:   op = OP_ENABLE;
      CMD_DISABLE:  op = OP_DISABLE;
      default:      known = 1'b0;
    endcase
  end

  assign set_prod = (32 + MW)'(f1_us) * (32 + MW)'(CLOCK_MHZ);
  assign min_prod = (16 + MW)'(min_interval) * (16 + MW)'(CLOCK_MHZ);

  always_comb begin
    q_wdata.op        = op;
    q_wdata.req_count = (set_prod > (32 + MW)'(CNT_MASK)) ? CNT_MASK : set_prod[31:0];
    q_wdata.min_count = (32'(min_prod) > CNT_MASK) ? CNT_MASK : 32'(min_prod);
    q_wdata.is_max    = f1_us == MAX_US;
  end

  // Unused command codes are dropped here
  assign q_push = f1_valid && known;

endmodule

@@ rtl/tint_queue.sv @@
// ----------------------------------------------------------------------------
// tint_queue: small FIFO between front and back
// Register-based, one push and one pop per cycle, level exported for credit.
// ----------------------------------------------------------------------------
module tint_queue import tint_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  q_item_t           push_item,
  input  logic              pop,
  output logic              head_valid,
  output q_item_t           head_item,
  output logic [QLVL_W-1:0] level
);

  q_item_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      level <= level + QLVL_W'(push) - QLVL_W'(pop);
    end
  end

  assign head_valid = level != '0;
  assign head_item  = entries[rd_ptr];

endmodule

@@ rtl/tint_back.sv @@
// ----------------------------------------------------------------------------
// tint_back: timer state and command execution
// Down-counter, reload, totals and the unreported count with its residue
// modulo the clock rate. Set-interval runs a short sequence that refreshes
// the residues through a divide pipeline.
// ----------------------------------------------------------------------------
module tint_back import tint_pkg::*; #(
  parameter int CLOCK_MHZ    = 64,
  parameter int COUNTER_BITS = 24
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  q_item_t head_item,
  output logic    pop,
  output logic    res_valid,
  input  logic    res_ready,
  output res_t    res
);

  localparam int          MW       = $clog2(CLOCK_MHZ + 1);
  localparam int          RW       = (CLOCK_MHZ > 1) ? $clog2(CLOCK_MHZ) : 1;
  localparam int          XW       = MW + 1;
  localparam logic [31:0] CNT_MASK = cnt_mask(COUNTER_BITS);
  localparam logic [63:0] P64      = 64'h1_0000_0000 % 64'(CLOCK_MHZ);
  localparam logic [31:0] RLD_MOD  = CNT_MASK % 32'(CLOCK_MHZ);
  localparam logic [XW-1:0] M_X    = XW'(CLOCK_MHZ);
  localparam logic [XW-1:0] P_X    = XW'(P64);
  localparam logic [COUNTER_BITS-1:0] COUNT_100 = COUNTER_BITS'(100 * CLOCK_MHZ);

  typedef enum logic [4:0] {
    ST_RUN   = 5'b00001,
    ST_PICK  = 5'b00010,
    ST_LOAD  = 5'b00100,
    ST_REM_U = 5'b01000,
    ST_REM_R = 5'b10000
  } back_state_t;

  back_state_t             state;
  logic [COUNTER_BITS-1:0] down;
  logic [COUNTER_BITS-1:0] reload;
  logic [31:0]             total;
  logic [31:0]             unrep;
  logic [RW-1:0]           unrep_mod;
  logic [RW-1:0]           reload_mod;
  logic                    running;
  logic                    enabled;
  logic [31:0]             lat_set;
  logic [31:0]             lat_min;
  logic                    lat_is_max;

  logic                    down_zero;
  logic [31:0]             elapsed;
  logic [COUNTER_BITS-1:0] cur;
  logic                    wrap;
  logic [32:0]             wrap_sum;
  logic [XW-1:0]           mod_sum;
  logic [XW-1:0]           mod_red;
  logic [XW-1:0]           mod_next;
  logic                    has_result;
  logic                    in_run;
  logic [31:0]             short_count;
  logic [31:0]             pick;
  logic [31:0]             div_in;
  logic [RW-1:0]           div_rem;

  assign down_zero = down == '0;
  assign elapsed   = down_zero ? 32'd0 : 32'(reload) - 32'(down);
  assign cur       = down_zero ? reload : down;
  assign wrap      = cur <= COUNTER_BITS'(1);
  assign wrap_sum  = {1'b0, unrep} + 33'(reload);

  // Residue of (unrep + reload) mod 2^32, from the two stored residues
  always_comb begin
    mod_sum = XW'(unrep_mod) + XW'(reload_mod);
    mod_red = (mod_sum >= M_X) ? mod_sum - M_X : mod_sum;
    if (!wrap_sum[32]) begin
      mod_next = mod_red;
    end else if (mod_red >= P_X) begin
      mod_next = mod_red - P_X;
    end else begin
      mod_next = mod_red + M_X - P_X;
    end
  end

  assign in_run = state == ST_RUN;

  always_comb begin
    has_result   = 1'b0;
    res.kind     = KIND_EXPIRY;
    res.dividend = wrap_sum[31:0];
    unique case (head_item.op)
      OP_TICK: has_result = running && wrap;
      OP_RD_UNREP: begin
        has_result   = 1'b1;
        res.kind     = KIND_UNREP;
        res.dividend = elapsed + unrep;
      end
      OP_RD_TIME: begin
        has_result   = 1'b1;
        res.kind     = KIND_TIME;
        res.dividend = total + elapsed;
      end
      default: has_result = 1'b0;
    endcase
  end

  assign res_valid = head_valid && in_run && has_result;
  assign pop       = head_valid && in_run && (!has_result || res_ready);

  // New reload after the fold: 100 us when reported ran ahead, else shortened
  always_comb begin
    short_count = lat_set - unrep;
    if (unrep[31]) begin
      pick = 32'(COUNT_100);
    end else if (!lat_is_max && (lat_set > unrep)) begin
      pick = (short_count < lat_min) ? lat_min : short_count;
    end else begin
      pick = lat_set;
    end
  end

  assign div_in = (state == ST_LOAD) ? 32'(reload) : unrep;

  tint_div #(
    .CLOCK_MHZ(CLOCK_MHZ)
  ) u_rem_div (
    .clk      (clk),
    .advance  (1'b1),
    .dividend (div_in),
    .quotient (),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (pop && (head_item.op == OP_SET)) begin
      lat_set    <= head_item.req_count;
      lat_min    <= head_item.min_count;
      lat_is_max <= head_item.is_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      down       <= '0;
      reload     <= CNT_MASK[COUNTER_BITS-1:0];
      total      <= '0;
      unrep      <= '0;
      unrep_mod  <= '0;
      reload_mod <= RLD_MOD[RW-1:0];
      running    <= 1'b1;
      enabled    <= 1'b1;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (pop) begin
            case (head_item.op)
              OP_TICK: begin
                if (running) begin
                  if (wrap) begin
                    total     <= total + 32'(reload);
                    down      <= '0;
                    unrep     <= 32'(mod_next);
                    unrep_mod <= mod_next[RW-1:0];
                  end else begin
                    down <= cur - COUNTER_BITS'(1);
                  end
                end
              end
              OP_SET: begin
                total <= total + elapsed;
                unrep <= unrep + elapsed;
                down  <= '0;
                if (!enabled) begin
                  running <= 1'b1;
                end
                state <= ST_PICK;
              end
              OP_STOP: begin
                running <= 1'b0;
                enabled <= 1'b0;
              end
              OP_ENABLE: begin
                if (!enabled) begin
                  enabled <= 1'b1;
                  running <= 1'b1;
                end
              end
              OP_DISABLE: running <= 1'b0;
              default: ;
            endcase
          end
        end
        ST_PICK: begin
          reload <= pick[COUNTER_BITS-1:0];
          state  <= ST_LOAD;
        end
        ST_LOAD:  state <= ST_REM_U;
        ST_REM_U: begin
          unrep_mod <= div_rem;
          state     <= ST_REM_R;
        end
        ST_REM_R: begin
          reload_mod <= div_rem;
          state      <= ST_RUN;
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

@@ rtl/tint_out.sv @@
// ----------------------------------------------------------------------------
// tint_out: result divide pipeline and output register
// Converts counts to microseconds; the whole pipe freezes while the output
// register is stalled.
// ----------------------------------------------------------------------------
module tint_out import tint_pkg::*; #(
  parameter int CLOCK_MHZ = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      res_valid,
  input  res_t      res,
  output logic      res_ready,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp_item
);

  logic        advance;
  logic        v1;
  logic        v2;
  logic [1:0]  k1;
  logic [1:0]  k2;
  logic [31:0] quot;

  assign advance   = !rsp_valid || !rsp_stall;
  assign res_ready = advance;

  tint_div #(
    .CLOCK_MHZ(CLOCK_MHZ)
  ) u_out_div (
    .clk      (clk),
    .advance  (advance),
    .dividend (res.dividend),
    .quotient (quot),
    .remainder()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (advance) begin
      v1        <= res_valid;
      v2        <= v1;
      rsp_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      k1                <= res.kind;
      k2                <= k1;
      rsp_item.kind     <= k2;
      rsp_item.value_us <= quot;
    end
  end

endmodule

@@ rtl/tint_checker.sv @@
// ----------------------------------------------------------------------------
// tint_checker: port-level checks for the interval timer
// Reset state of the channels, output hold under stall and intake credit.
// ----------------------------------------------------------------------------
module tint_checker import tint_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_stall,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input out_item_t rsp_item
);

  // Leaving reset, no result is pending and intake is open
  a_reset_clean: assert property (@(posedge clk)
    $fell(rst) |-> !rsp_valid && !cmd_stall)
    else $error("result pending or intake stalled right after reset");

  // Intake only closes after a transfer fills the last credit
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (cmd_stall && !$past(rst)) |-> $past(cmd_valid && !cmd_stall) || $past(cmd_stall))
    else $error("intake stalled without a preceding transfer");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp_item))
    else $error("result changed while stalled");

endmodule

bind tickless_interval_timer_top tint_checker u_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the tickless interval timer
// Queue-fed bursty command driver, randomly stalling result monitor, and an
// in-bench timer predictor that checks every result transfer by field.
// ----------------------------------------------------------------------------
module tb_top;
  import tint_pkg::*;

  // Block configuration, mirrored by the predictor
  localparam bit [31:0] CLK_MHZ    = 32'd64;
  localparam bit [31:0] CNT_MAX    = 32'h00FF_FFFF;       // 24-bit counter mask
  localparam bit [31:0] MAX_US     = CNT_MAX / CLK_MHZ;   // largest interval
  localparam bit [31:0] AHEAD_US   = 32'd100;             // reload when reported runs ahead
  localparam bit [31:0] FOREVER_US = 32'hFFFF_FFFF;       // stops the timer

  // Command codes the block does not decode
  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;

  localparam int          SETTLE_CYCLES = 40;         // pipe + queued set-intervals
  localparam int unsigned RUN_LIMIT_NS  = 4_000_000;

  typedef enum bit [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  in_item_t    cmd_item  = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  out_item_t   rsp_item;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Pending commands and the results they are predicted to produce
  in_item_t  cmd_backlog[$];
  out_item_t timer_results_due[$];
  int        n_errors = 0;

  // Predictor state, reset values as the block's
  bit [31:0] m_down     = 32'd0;
  bit [31:0] m_reload   = CNT_MAX;
  bit [31:0] m_total    = 32'd0;
  bit [31:0] m_reported = 32'd0;
  bit        m_running  = 1'b1;
  bit        m_enabled  = 1'b1;
  bit [15:0] m_min_us   = MIN_INTERVAL_RST;

  tickless_interval_timer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Timer predictor
  // --------------------------------------------------------------------------

  // Microseconds to counter clocks, saturated to the counter mask
  function automatic bit [31:0] us_counts(bit [63:0] us);
    bit [63:0] c;
    c = us * CLK_MHZ;
    return (c > CNT_MAX) ? CNT_MAX : c[31:0];
  endfunction

  // Clocks spent in the current period; zero before its first counted clock
  function automatic bit [31:0] elapsed_counts();
    return (m_down == 32'd0) ? 32'd0 : m_reload - m_down;
  endfunction

  task automatic timer_step(input in_item_t cmd, output bit has_res, output out_item_t res);
    bit [31:0] cnt;
    bit [31:0] us;
    bit [31:0] set_cnt;
    bit [31:0] min_cnt;
    bit [31:0] unrep;
    bit [31:0] sum;
    has_res = 1'b0;
    res     = '0;
    case (cmd.command)
      CMD_TICK: begin
        // ignored while stopped
        if (m_running) begin
          cnt = (m_down == 32'd0) ? m_reload : m_down;
          if (cnt <= 32'd1) begin
            // period ends: report whole us, keep sub-us remainder unreported
            m_total    = m_total + m_reload;
            m_down     = 32'd0;
            us         = (m_total - m_reported) / CLK_MHZ;
            m_reported = m_reported + us * CLK_MHZ;
            has_res    = 1'b1;
            res.kind   = KIND_EXPIRY;
            res.value_us = us;
          end else begin
            m_down = (cnt - 32'd1) & CNT_MAX;
          end
        end
      end
      CMD_SET: begin
        if (cmd.period_us == FOREVER_US) begin
          m_running = 1'b0;
          m_enabled = 1'b0;
        end else begin
          // flag stays clear; only the counter restarts
          if (!m_enabled) m_running = 1'b1;
          us = cmd.period_us;
          if (us > MAX_US) us = MAX_US;
          else if (us < m_min_us) us = m_min_us;
          set_cnt = us_counts(us);
          min_cnt = us_counts(m_min_us);
          m_total = m_total + elapsed_counts();
          unrep   = m_total - m_reported;
          if (unrep[31]) begin
            m_reload = us_counts(AHEAD_US);
          end else begin
            // shorten by what is still unreported, not below the minimum
            if (us != MAX_US && set_cnt > unrep) begin
              set_cnt = set_cnt - unrep;
              if (set_cnt < min_cnt) set_cnt = min_cnt;
            end
            m_reload = set_cnt & CNT_MAX;
          end
          m_down = 32'd0;
        end
      end
      CMD_RD_UNREP: begin
        sum          = elapsed_counts() + m_total - m_reported;
        has_res      = 1'b1;
        res.kind     = KIND_UNREP;
        res.value_us = sum / CLK_MHZ;
      end
      CMD_RD_TIME: begin
        sum          = m_total + elapsed_counts();
        has_res      = 1'b1;
        res.kind     = KIND_TIME;
        res.value_us = sum / CLK_MHZ;
      end
      CMD_ENABLE: begin
        if (!m_enabled) begin
          m_enabled = 1'b1;
          m_running = 1'b1;
        end
      end
      CMD_DISABLE: m_running = 1'b0;
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // --------------------------------------------------------------------------
  // Command driver: bursts of random length, random gaps between them.
  // A stalled transfer holds valid and payload.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    bit        nxt_valid;
    bit        has_res;
    out_item_t res;
    in_item_t  taken;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        taken = cmd_backlog.pop_front();
        timer_step(taken, has_res, res);
        if (has_res) timer_results_due.push_back(res);
      end
      if (cmd_valid && cmd_stall) begin
        nxt_valid = 1'b1;
      end else begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() != 0) begin
          nxt_valid = 1'b1;
          if (burst_left <= 1) begin
            // end of burst: pick the next one and the gap ahead of it
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
      cmd_valid <= nxt_valid;
      if (nxt_valid) cmd_item <= cmd_backlog[0];
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each transfer against the oldest prediction and
  // drives rsp_stall from a mode that is picked anew at random intervals.
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode      = STALL_NONE;
  int          stall_mode_left = 0;
  int unsigned stall_phase     = 0;

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (timer_results_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d value %0d",
                                  rsp_item.kind, rsp_item.value_us));
        end else begin
          want = timer_results_due.pop_front();
          if (rsp_item.kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, predicted %0d", rsp_item.kind, want.kind));
          if (rsp_item.value_us !== want.value_us)
            flag_mismatch($sformatf("value_us %0d, predicted %0d (kind %0d)",
                                    rsp_item.value_us, want.value_us, want.kind));
        end
      end
      if (stall_mode_left == 0) begin
        stall_mode      = stall_mode_t'($urandom_range(0, 3));
        stall_mode_left = $urandom_range(32, 256);
      end else begin
        stall_mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        STALL_NONE:  rsp_stall <= 1'b0;
        STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
        default:     rsp_stall <= ((stall_phase % 7) < 3);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_cmd(logic [2:0] code, logic [31:0] interval);
    in_item_t it;
    it.command   = code;
    it.period_us = interval;
    cmd_backlog.push_back(it);
  endfunction

  // Interval mix: mostly near the minimum so periods are short enough to expire
  function automatic bit [31:0] pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, m_min_us + 3);
    if (r < 70) return $urandom_range(0, 4 * m_min_us + 64);
    if (r < 80) return $urandom_range(0, MAX_US + 2);
    if (r < 86) return MAX_US;
    if (r < 92) return FOREVER_US;
    return $urandom();
  endfunction

  // Sender holds off until the block has returned every predicted result
  task automatic wait_idle();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || timer_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One setting of the minimum interval, then random traffic under it.
  // Most traffic is a set-interval (sometimes after a stop/enable restart)
  // followed by a run of ticks with reads mixed in; the rest is noise.
  task automatic run_phase(input bit [15:0] min_us, input int n_items);
    int queued;
    int pick;
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= min_us;
    @(posedge clk);
    cfg_we    <= 1'b0;
    m_min_us = min_us;
    queued = 0;
    while (queued < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if (pick < 25) begin
          queue_cmd(CMD_SET, FOREVER_US);
          queue_cmd(CMD_ENABLE, $urandom());
          queued += 2;
        end
        queue_cmd(CMD_SET, pick_interval());
        queued++;
        repeat ($urandom_range(8, 160)) begin
          if (queued >= n_items) break;
          pick = $urandom_range(0, 99);
          if (pick < 6)       queue_cmd(CMD_RD_UNREP, $urandom());
          else if (pick < 10) queue_cmd(CMD_RD_TIME, $urandom());
          else if (pick < 11) queue_cmd(CMD_SET, pick_interval());
          else                queue_cmd(CMD_TICK, $urandom());
          queued++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          queue_cmd(3'($urandom_range(0, 7)), pick_interval());
          queued++;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed pass at the reset minimum of 50 us
    queue_cmd(CMD_RD_UNREP, 32'd0);
    queue_cmd(CMD_RD_TIME, 32'd0);
    queue_cmd(CMD_TICK, 32'd0);              // first tick loads the all-ones reload
    queue_cmd(CMD_RD_TIME, 32'hFFFF_FFFF);
    queue_cmd(CMD_SET, 32'd0);               // below minimum, clamped up to it
    queue_cmd(CMD_SET, MAX_US);              // exactly the maximum, no shortening
    queue_cmd(CMD_SET, MAX_US + 1);          // clamped down
    queue_cmd(CMD_SET, 32'hFFFF_FFFE);
    queue_cmd(CMD_SET, FOREVER_US);          // stop, flag clear
    queue_cmd(CMD_TICK, 32'hFFFF_FFFF);      // stopped: ignored
    queue_cmd(CMD_RD_UNREP, 32'd0);
    queue_cmd(CMD_SET, 32'd7);               // restarts while flag stays clear
    queue_cmd(CMD_ENABLE, 32'd0);
    queue_cmd(CMD_ENABLE, 32'd0);            // flag already set: no effect
    queue_cmd(CMD_DISABLE, 32'd0);
    queue_cmd(CMD_TICK, 32'd0);              // disabled: ignored
    queue_cmd(CMD_RSVD_A, 32'd0);
    queue_cmd(CMD_RSVD_B, 32'hFFFF_FFFF);
    queue_cmd(CMD_ENABLE, 32'd0);            // flag set, so timer stays stopped
    queue_cmd(CMD_SET, FOREVER_US);
    queue_cmd(CMD_ENABLE, 32'd0);
    queue_cmd(CMD_SET, 32'd1);
    queue_cmd(CMD_TICK, 32'h5555_5555);
    queue_cmd(CMD_RD_UNREP, 32'hAAAA_AAAA);
    queue_cmd(CMD_RD_TIME, 32'd0);

    // Random passes; minimum of zero gives zero-length periods
    run_phase(16'd1, 240);
    run_phase(16'd0, 230);
    run_phase(16'd3, 230);
    run_phase(16'hFFFF, 230);
    run_phase(16'($urandom_range(4, 400)), 230);
    run_phase(16'd1, 240);

    wait_idle();
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("TIMEOUT: %0d results still due", timer_results_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
